### sv/rgbf_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED frame buffer package
// Shared types, opcodes, palette and sizing constants for the frame encoder.
// ----------------------------------------------------------------------------
package rgbf_pkg;

    // Number of LEDs in the chain and the width of a table address
    localparam int LED_COUNT = 32;
    localparam int SLOT_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LED_COUNT - 1);

    // Opcodes
    localparam logic [3:0] OP_SET_RGB = 4'd0;
    localparam logic [3:0] OP_SET_PAL = 4'd1;
    localparam logic [3:0] OP_OFF     = 4'd2;
    localparam logic [3:0] OP_ON      = 4'd3;
    localparam logic [3:0] OP_ALL_RGB = 4'd4;
    localparam logic [3:0] OP_ALL_PAL = 4'd5;
    localparam logic [3:0] OP_ALL_OFF = 4'd6;
    localparam logic [3:0] OP_ALL_ON  = 4'd7;
    localparam logic [3:0] OP_UPDATE  = 4'd8;

    // Palette codes
    localparam logic [3:0] PAL_BLACK      = 4'd0;
    localparam logic [3:0] PAL_WHITE      = 4'd1;
    localparam logic [3:0] PAL_RED        = 4'd2;
    localparam logic [3:0] PAL_BLUE       = 4'd3;
    localparam logic [3:0] PAL_YELLOW     = 4'd4;
    localparam logic [3:0] PAL_CYAN       = 4'd5;
    localparam logic [3:0] PAL_MAGENTA    = 4'd6;
    localparam logic [3:0] PAL_GREEN      = 4'd7;
    localparam logic [3:0] PAL_AQUA       = 4'd8;
    localparam logic [3:0] PAL_PURPLE     = 4'd9;
    localparam logic [3:0] PAL_LIGHT_BLUE = 4'd10;
    localparam logic [3:0] PAL_ORANGE     = 4'd11;
    localparam logic [3:0] PAL_INDIGO     = 4'd12;

    // Frame delimiters
    localparam logic [31:0] START_WORD = 32'h0000_0000;
    localparam logic [31:0] END_WORD   = 32'hFFFF_FFFF;
    localparam logic [2:0]  LED_MARK   = 3'b111;

    // One input beat
    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] led_position;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [3:0] palette_code;
        logic [7:0] brightness;
        logic       force_send;
    } rgbf_cmd_t;

    // One output beat
    typedef struct packed {
        logic [31:0] frame_word;
        logic        last_word;
    } rgbf_result_t;

    // One table entry
    typedef struct packed {
        logic [4:0] bright;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgbf_entry_t;

    // Table access request from the controller
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        rgbf_entry_t       wr_data;
    } rgbf_tbl_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_TAIL
    } rgbf_state_t;

    // Named colour as {red, green, blue}
    function automatic logic [23:0] palette_rgb(input logic [3:0] code);
        logic [23:0] rgb;
        case (code)
            PAL_BLACK:      rgb = 24'h000000;
            PAL_WHITE:      rgb = 24'hFFFFFF;
            PAL_RED:        rgb = 24'hFF0000;
            PAL_BLUE:       rgb = 24'h0000FF;
            PAL_YELLOW:     rgb = 24'hFFFF00;
            PAL_CYAN:       rgb = 24'h00FFFF;
            PAL_MAGENTA:    rgb = 24'hFF00FF;
            PAL_GREEN:      rgb = 24'h00FF00;
            PAL_AQUA:       rgb = 24'h00FFFF;
            PAL_PURPLE:     rgb = 24'h800080;
            PAL_LIGHT_BLUE: rgb = 24'hADD8E6;
            PAL_ORANGE:     rgb = 24'hFFA500;
            PAL_INDIGO:     rgb = 24'h4B0082;
            default:        rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

### sv/rgb_led_frame_buffer_encoder_core.sv
// ----------------------------------------------------------------------------
// RGB LED frame buffer and serial frame encoder
// Per-LED colour/brightness table with command decode and frame output.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on cmd and are taken when start is high and busy low.
//   Results leave on result, at most one 32-bit word per cycle marked by
//   word_strobe; the receiver must take every beat, there is no back-pressure.
//   cfg_data sets the brightness limit on a cfg_valid beat (cfg_ready is
//   always high); write it only while the block is idle.
// Timing (LED_COUNT = 32):
//   Set rgb / set palette: written in the accept cycle, busy stays low.
//   Off / on of one LED: read-modify-write, busy high for a single cycle; busy stays low if out of range.
//   All-LED commands: one table entry per cycle, busy in the walk and drain states.
//   Update, if modified or forced: start word in the cycle after accept, LED
//   words next, end word last with last_word set; busy in the walk, drain and
//   tail states. The single table read port sets the pace.
// Reset: table reads as all dark, modified flag set, limit at 31.
// ----------------------------------------------------------------------------
module rgb_led_frame_buffer_encoder_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rgbf_pkg::rgbf_cmd_t    cmd,
    output logic                   word_strobe,
    output rgbf_pkg::rgbf_result_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [4:0]             cfg_data
);

    logic [4:0]              max_bright_reg;
    rgbf_pkg::rgbf_tbl_req_t tbl_req;
    rgbf_pkg::rgbf_entry_t   tbl_data;

    // Brightness limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bright_reg <= 5'd31;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_bright_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    rgbf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .max_bright  (max_bright_reg),
        .busy        (busy),
        .tbl_req     (tbl_req),
        .tbl_data    (tbl_data),
        .word_strobe (word_strobe),
        .result      (result)
    );

    rgbf_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_data)
    );

endmodule

### sv/rgbf_table.sv
// ----------------------------------------------------------------------------
// LED table memory
// One write and one read port, registered read; unwritten entries read zero.
// ----------------------------------------------------------------------------
module rgbf_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rgbf_pkg::rgbf_tbl_req_t req,
    output rgbf_pkg::rgbf_entry_t   rd_data
);

    rgbf_pkg::rgbf_entry_t       mem [rgbf_pkg::LED_COUNT];
    logic [rgbf_pkg::LED_COUNT-1:0] valid_reg;
    rgbf_pkg::rgbf_entry_t       q_reg;
    logic                        q_valid_reg;

    // Storage array and read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.rd_addr];
        end
    end

    // Per-entry written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                q_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

### sv/rgbf_ctrl.sv
// ----------------------------------------------------------------------------
// Frame buffer controller
// Decodes commands, walks the table with read-modify-write and emits frames.
// ----------------------------------------------------------------------------
module rgbf_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rgbf_pkg::rgbf_cmd_t     cmd,
    input  logic [4:0]              max_bright,
    output logic                    busy,
    output rgbf_pkg::rgbf_tbl_req_t tbl_req,
    input  rgbf_pkg::rgbf_entry_t   tbl_data,
    output logic                    word_strobe,
    output rgbf_pkg::rgbf_result_t  result
);

    rgbf_pkg::rgbf_state_t state_reg, state_next;

    logic [3:0]                  op_reg, op_next;
    rgbf_pkg::rgbf_entry_t       entry_reg, entry_next;
    logic [4:0]                  bright_reg, bright_next;
    logic [rgbf_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                        act_valid_reg, act_valid_next;
    logic [rgbf_pkg::SLOT_W-1:0] act_addr_reg, act_addr_next;
    logic                        dirty_reg, dirty_next;
    logic                        strobe_reg, strobe_next;
    logic [31:0]                 word_reg, word_next;
    logic                        last_reg, last_next;

    logic [7:0]                  pos_eff;
    logic [7:0]                  pos_m1;
    logic [rgbf_pkg::SLOT_W-1:0] cmd_slot;
    logic                        cmd_in_range;
    logic [4:0]                  cmd_bright;
    logic [23:0]                 pal_rgb;
    rgbf_pkg::rgbf_entry_t       cmd_entry;
    logic                        send_frame;

    // Command decode: slot, saturated brightness, entry to store
    always_comb
    begin
        pos_eff      = (cmd.led_position == 8'd0) ? 8'd1 : cmd.led_position;
        pos_m1       = pos_eff - 8'd1;
        cmd_slot     = pos_m1[rgbf_pkg::SLOT_W-1:0];
        cmd_in_range = (pos_eff <= 8'(rgbf_pkg::LED_COUNT));
        cmd_bright   = (cmd.brightness > {3'b000, max_bright}) ? max_bright
                                                               : cmd.brightness[4:0];
        pal_rgb      = rgbf_pkg::palette_rgb(cmd.palette_code);
        cmd_entry.bright = cmd_bright;
        if ((cmd.opcode == rgbf_pkg::OP_SET_PAL) || (cmd.opcode == rgbf_pkg::OP_ALL_PAL))
        begin
            cmd_entry.red   = pal_rgb[23:16];
            cmd_entry.green = pal_rgb[15:8];
            cmd_entry.blue  = pal_rgb[7:0];
        end
        else
        begin
            cmd_entry.red   = cmd.red_level;
            cmd_entry.green = cmd.green_level;
            cmd_entry.blue  = cmd.blue_level;
        end
        send_frame = dirty_reg || cmd.force_send;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rgbf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.opcode)
                        rgbf_pkg::OP_OFF, rgbf_pkg::OP_ON:
                            if (cmd_in_range)
                            begin
                                state_next = rgbf_pkg::ST_DRAIN;
                            end
                        rgbf_pkg::OP_ALL_RGB, rgbf_pkg::OP_ALL_PAL,
                        rgbf_pkg::OP_ALL_OFF, rgbf_pkg::OP_ALL_ON:
                            state_next = rgbf_pkg::ST_WALK;
                        rgbf_pkg::OP_UPDATE:
                            if (send_frame)
                            begin
                                state_next = rgbf_pkg::ST_WALK;
                            end
                        default:
                            state_next = rgbf_pkg::ST_IDLE;
                    endcase
                end
            end
            rgbf_pkg::ST_WALK:
            begin
                if (idx_reg == rgbf_pkg::LAST_SLOT)
                begin
                    state_next = rgbf_pkg::ST_DRAIN;
                end
            end
            rgbf_pkg::ST_DRAIN:
            begin
                state_next = (op_reg == rgbf_pkg::OP_UPDATE) ? rgbf_pkg::ST_TAIL
                                                             : rgbf_pkg::ST_IDLE;
            end
            rgbf_pkg::ST_TAIL:
                state_next = rgbf_pkg::ST_IDLE;
            default:
                state_next = rgbf_pkg::ST_IDLE;
        endcase
    end

    // Outputs: table requests and register next values
    always_comb
    begin
        op_next        = op_reg;
        entry_next     = entry_reg;
        bright_next    = bright_reg;
        idx_next       = idx_reg;
        act_valid_next = 1'b0;
        act_addr_next  = act_addr_reg;
        dirty_next     = dirty_reg;
        strobe_next    = 1'b0;
        word_next      = word_reg;
        last_next      = 1'b0;
        tbl_req        = '0;

        case (state_reg)
            rgbf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.opcode;
                    entry_next  = cmd_entry;
                    idx_next    = '0;
                    bright_next = ((cmd.opcode == rgbf_pkg::OP_OFF) ||
                                   (cmd.opcode == rgbf_pkg::OP_ALL_OFF)) ? 5'd0 : cmd_bright;
                    case (cmd.opcode)
                        rgbf_pkg::OP_SET_RGB, rgbf_pkg::OP_SET_PAL:
                        begin
                            // single entry written straight away
                            tbl_req.wr_en   = cmd_in_range;
                            tbl_req.wr_addr = cmd_slot;
                            tbl_req.wr_data = cmd_entry;
                            if ((cmd.opcode == rgbf_pkg::OP_SET_RGB) || cmd_in_range)
                            begin
                                dirty_next = 1'b1;
                            end
                        end
                        rgbf_pkg::OP_OFF, rgbf_pkg::OP_ON:
                        begin
                            tbl_req.rd_en   = cmd_in_range;
                            tbl_req.rd_addr = cmd_slot;
                            act_valid_next  = cmd_in_range;
                            act_addr_next   = cmd_slot;
                            dirty_next      = 1'b1;
                        end
                        rgbf_pkg::OP_ALL_RGB, rgbf_pkg::OP_ALL_PAL,
                        rgbf_pkg::OP_ALL_OFF, rgbf_pkg::OP_ALL_ON:
                            dirty_next = 1'b1;
                        rgbf_pkg::OP_UPDATE:
                        begin
                            dirty_next = 1'b0;
                            if (send_frame)
                            begin
                                strobe_next = 1'b1;
                                word_next   = rgbf_pkg::START_WORD;
                            end
                        end
                        default:
                            dirty_next = dirty_reg;
                    endcase
                end
            end
            rgbf_pkg::ST_WALK:
            begin
                // issue the read of the next entry
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = idx_reg;
                act_valid_next  = 1'b1;
                act_addr_next   = idx_reg;
                idx_next        = idx_reg + 1'b1;
            end
            rgbf_pkg::ST_TAIL:
            begin
                strobe_next = 1'b1;
                word_next   = rgbf_pkg::END_WORD;
                last_next   = 1'b1;
            end
            default:
                idx_next = idx_reg;
        endcase

        // Modify-and-write or frame-word stage, in the cycle after the read
        if (act_valid_reg)
        begin
            case (op_reg)
                rgbf_pkg::OP_UPDATE:
                begin
                    strobe_next = 1'b1;
                    word_next   = {rgbf_pkg::LED_MARK, tbl_data};
                end
                rgbf_pkg::OP_ALL_RGB, rgbf_pkg::OP_ALL_PAL:
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = act_addr_reg;
                    tbl_req.wr_data = entry_reg;
                end
                default:
                begin
                    tbl_req.wr_en          = 1'b1;
                    tbl_req.wr_addr        = act_addr_reg;
                    tbl_req.wr_data        = tbl_data;
                    tbl_req.wr_data.bright = bright_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgbf_pkg::ST_IDLE;
            act_valid_reg <= 1'b0;
            dirty_reg     <= 1'b1;
            strobe_reg    <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_valid_reg <= act_valid_next;
            dirty_reg     <= dirty_next;
            strobe_reg    <= strobe_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        entry_reg    <= entry_next;
        bright_reg   <= bright_next;
        act_addr_reg <= act_addr_next;
        word_reg     <= word_next;
        last_reg     <= last_next;
    end

    assign busy              = (state_reg != rgbf_pkg::ST_IDLE);
    assign word_strobe       = strobe_reg;
    assign result.frame_word = word_reg;
    assign result.last_word  = last_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB LED frame encoder testbench
// Drives commands through the start/busy port and checks every frame word
// against a tracker that mirrors the LED table, the modified flag and the
// brightness limit. The brightness limit is changed between phases.
// ----------------------------------------------------------------------------
module testbench;

    import rgbf_pkg::*;

    localparam int RANDOM_PER_PHASE = 38;
    localparam int SETTLE_CYCLES    = LED_COUNT + 6;
    localparam int CYCLE_LIMIT      = 200000;

    // Mirror of the LED table; predicts the words of every frame
    class led_frame_tracker;
        rgbf_entry_t  leds [LED_COUNT];
        bit           dirty;
        logic [4:0]   limit;
        rgbf_result_t expected_words [$];
        int           errors;
        int           commands;
        int           frames;
        int           words_checked;

        function void clear_state();
            foreach (leds[i])
            begin
                leds[i] = '0;
            end
            dirty = 1'b1;
            limit = 5'd31;
            expected_words.delete();
            errors        = 0;
            commands      = 0;
            frames        = 0;
            words_checked = 0;
        endfunction

        function void set_limit(logic [4:0] value);
            limit = value;
        endfunction

        // {red, green, blue} of a named colour; unnamed codes are black
        function logic [23:0] named_colour(logic [3:0] code);
            case (code)
                PAL_WHITE:      return 24'hFFFFFF;
                PAL_RED:        return 24'hFF0000;
                PAL_BLUE:       return 24'h0000FF;
                PAL_YELLOW:     return 24'hFFFF00;
                PAL_CYAN:       return 24'h00FFFF;
                PAL_MAGENTA:    return 24'hFF00FF;
                PAL_GREEN:      return 24'h00FF00;
                PAL_AQUA:       return 24'h00FFFF;
                PAL_PURPLE:     return 24'h800080;
                PAL_LIGHT_BLUE: return 24'hADD8E6;
                PAL_ORANGE:     return 24'hFFA500;
                PAL_INDIGO:     return 24'h4B0082;
                default:        return 24'h000000;
            endcase
        endfunction

        function logic [4:0] clip(logic [7:0] req);
            return (req > {3'b000, limit}) ? limit : req[4:0];
        endfunction

        // Position zero means the first LED; -1 when past the chain
        function int slot_of_position(logic [7:0] pos);
            int p;
            p = (pos == 8'd0) ? 1 : int'(pos);
            return (p > LED_COUNT) ? -1 : p - 1;
        endfunction

        function rgbf_entry_t colour_entry(logic [4:0] b, logic [23:0] rgb);
            rgbf_entry_t e;
            e.bright = b;
            e.red    = rgb[23:16];
            e.green  = rgb[15:8];
            e.blue   = rgb[7:0];
            return e;
        endfunction

        function void expect_word(logic [31:0] word, logic last);
            rgbf_result_t w;
            w.frame_word = word;
            w.last_word  = last;
            expected_words.push_back(w);
        endfunction

        // Called on every accepted command beat
        function void note_command(rgbf_cmd_t c);
            int          slot;
            logic [4:0]  b;
            rgbf_entry_t rgb_e;
            rgbf_entry_t pal_e;
            slot  = slot_of_position(c.led_position);
            b     = clip(c.brightness);
            rgb_e = colour_entry(b, {c.red_level, c.green_level, c.blue_level});
            pal_e = colour_entry(b, named_colour(c.palette_code));
            commands++;
            case (c.opcode)
                OP_SET_RGB:
                begin
                    if (slot >= 0)
                        leds[slot] = rgb_e;
                    dirty = 1'b1;
                end
                // an out-of-range palette write leaves the flag alone
                OP_SET_PAL:
                begin
                    if (slot >= 0)
                    begin
                        leds[slot] = pal_e;
                        dirty = 1'b1;
                    end
                end
                OP_OFF:
                begin
                    if (slot >= 0)
                        leds[slot].bright = 5'd0;
                    dirty = 1'b1;
                end
                OP_ON:
                begin
                    if (slot >= 0)
                        leds[slot].bright = b;
                    dirty = 1'b1;
                end
                OP_ALL_RGB:
                begin
                    foreach (leds[i])
                        leds[i] = rgb_e;
                    dirty = 1'b1;
                end
                OP_ALL_PAL:
                begin
                    foreach (leds[i])
                        leds[i] = pal_e;
                    dirty = 1'b1;
                end
                OP_ALL_OFF:
                begin
                    foreach (leds[i])
                        leds[i].bright = 5'd0;
                    dirty = 1'b1;
                end
                OP_ALL_ON:
                begin
                    foreach (leds[i])
                        leds[i].bright = b;
                    dirty = 1'b1;
                end
                // frame goes out only when modified or forced
                OP_UPDATE:
                begin
                    if (dirty || c.force_send)
                    begin
                        frames++;
                        expect_word(START_WORD, 1'b0);
                        foreach (leds[i])
                            expect_word({LED_MARK, leds[i]}, 1'b0);
                        expect_word(END_WORD, 1'b1);
                    end
                    dirty = 1'b0;
                end
                default:
                begin
                end
            endcase
        endfunction

        // Called on every word_strobe beat
        function void check_word(rgbf_result_t got);
            rgbf_result_t want;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: stray word: expected none, actual %h last %b",
                         $time, got.frame_word, got.last_word);
                return;
            end
            want = expected_words.pop_front();
            if (got.frame_word !== want.frame_word)
            begin
                errors++;
                $display("%0t: frame_word: expected %h, actual %h",
                         $time, want.frame_word, got.frame_word);
            end
            if (got.last_word !== want.last_word)
            begin
                errors++;
                $display("%0t: last_word: expected %b, actual %b",
                         $time, want.last_word, got.last_word);
            end
        endfunction

        function void check_drained();
            if (expected_words.size() != 0)
            begin
                errors++;
                $display("%0t: %0d words never came: expected %h, actual none",
                         $time, expected_words.size(), expected_words[0].frame_word);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    rgbf_cmd_t    cmd;
    logic         word_strobe;
    rgbf_result_t result;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [4:0]   cfg_data;

    led_frame_tracker tracker;
    int               cycle_count;
    int               random_sent;

    rgb_led_frame_buffer_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .word_strobe (word_strobe),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Observe accepted beats at the rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (word_strobe)
                tracker.check_word(result);
            if (start && !busy)
                tracker.note_command(cmd);
            if (cfg_valid && cfg_ready)
                tracker.set_limit(cfg_data);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic rgbf_cmd_t make_cmd(logic [3:0] op, logic [7:0] pos,
                                           logic [23:0] rgb, logic [3:0] code,
                                           logic [7:0] bright, logic force_bit);
        rgbf_cmd_t c;
        c.opcode       = op;
        c.led_position = pos;
        c.red_level    = rgb[23:16];
        c.green_level  = rgb[15:8];
        c.blue_level   = rgb[7:0];
        c.palette_code = code;
        c.brightness   = bright;
        c.force_send   = force_bit;
        return c;
    endfunction

    // Mostly table writes and updates, some whole-chain commands and junk opcodes
    function automatic rgbf_cmd_t random_command();
        rgbf_cmd_t   c;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        c.red_level    = 8'($urandom);
        c.green_level  = 8'($urandom);
        c.blue_level   = 8'($urandom);
        c.palette_code = 4'($urandom_range(0, 15));
        c.force_send   = 1'($urandom);
        if ($urandom_range(0, 99) < 85)
            c.led_position = 8'($urandom_range(0, LED_COUNT));
        else
            c.led_position = 8'($urandom_range(LED_COUNT + 1, 255));
        case ($urandom_range(0, 3))
            0:       c.brightness = 8'($urandom_range(0, 31));
            1:       c.brightness = 8'($urandom_range(32, 255));
            default: c.brightness = 8'($urandom_range(0, 255));
        endcase
        if (pick < 22)
            c.opcode = OP_SET_RGB;
        else if (pick < 40)
            c.opcode = OP_SET_PAL;
        else if (pick < 50)
            c.opcode = OP_OFF;
        else if (pick < 60)
            c.opcode = OP_ON;
        else if (pick < 64)
            c.opcode = OP_ALL_RGB;
        else if (pick < 67)
            c.opcode = OP_ALL_PAL;
        else if (pick < 69)
            c.opcode = OP_ALL_OFF;
        else if (pick < 72)
            c.opcode = OP_ALL_ON;
        else if (pick < 94)
        begin
            c.opcode     = OP_UPDATE;
            c.force_send = ($urandom_range(0, 3) == 0);
        end
        else
            c.opcode = 4'(OP_UPDATE + 1 + $urandom_range(0, 6));
        return c;
    endfunction

    // Hold start until the block takes the beat
    task automatic send_command(input rgbf_cmd_t c);
        @(negedge clk);
        cmd   = c;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
            cmd   = rgbf_cmd_t'({$urandom, $urandom});
        end
    endtask

    // Wait for every frame word and for the table walk to finish
    task automatic wait_quiet();
        int k;
        idle_cycles(1);
        for (k = 0; k < 20 * SETTLE_CYCLES; k++)
        begin
            if (tracker.expected_words.size() == 0 && !busy)
                break;
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [4:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = 5'($urandom);
    endtask

    task automatic directed_sequence();
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_UPDATE, 8'd9, 24'h0, PAL_BLACK, 8'd0, 1'b1));
        // position zero lands on the first LED, brightness saturates
        send_command(make_cmd(OP_SET_RGB, 8'd0, 24'hFF00AA, PAL_BLACK, 8'd255, 1'b0));
        send_command(make_cmd(OP_SET_RGB, 8'd32, 24'h00FF55, PAL_BLACK, 8'd0, 1'b1));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        // palette write past the chain must not mark the frame modified
        send_command(make_cmd(OP_SET_PAL, 8'd255, 24'h0, PAL_WHITE, 8'd31, 1'b0));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        // rgb write past the chain still marks it
        send_command(make_cmd(OP_SET_RGB, 8'd33, 24'hFFFFFF, PAL_BLACK, 8'd200, 1'b0));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_OFF, 8'd1, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_ON, 8'd2, 24'h0, PAL_BLACK, 8'd17, 1'b0));
        send_command(make_cmd(OP_OFF, 8'd200, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_ON, 8'd0, 24'h0, PAL_BLACK, 8'd255, 1'b0));
        send_command(make_cmd(OP_SET_PAL, 8'd5, 24'h0, PAL_INDIGO, 8'd12, 1'b0));
        send_command(make_cmd(OP_SET_PAL, 8'd6, 24'h0, 4'd15, 8'd31, 1'b0));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_ALL_PAL, 8'd0, 24'h0, PAL_LIGHT_BLUE, 8'd64, 1'b0));
        send_command(make_cmd(OP_ALL_OFF, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_ALL_ON, 8'd0, 24'h0, PAL_BLACK, 8'd255, 1'b0));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
        send_command(make_cmd(OP_ALL_RGB, 8'd77, 24'h123456, 4'd13, 8'd3, 1'b1));
        // junk opcodes change nothing
        send_command(make_cmd(4'(OP_UPDATE + 1), 8'd1, 24'hFFFFFF, PAL_RED, 8'd9, 1'b1));
        send_command(make_cmd(4'hF, 8'd1, 24'hFFFFFF, PAL_RED, 8'd9, 1'b1));
        send_command(make_cmd(OP_UPDATE, 8'd0, 24'h0, PAL_BLACK, 8'd0, 1'b0));
    endtask

    // Random commands in bursts, with an occasional full drain
    task automatic random_phase(input int count);
        int        burst_left;
        int        sent;
        rgbf_cmd_t c;
        burst_left = 0;
        sent       = 0;
        while (sent < count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                    idle_cycles($urandom_range(1, 6));
            end
            c = random_command();
            send_command(c);
            burst_left--;
            if (c.opcode <= OP_UPDATE)
                sent++;
            if (c.opcode == OP_UPDATE && $urandom_range(0, 7) == 0)
                wait_quiet();
            if (sent == count / 2)
                wait_quiet();
        end
        random_sent += sent;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 5'd0;
        cycle_count = 0;
        random_sent = 0;
        tracker     = new;
        tracker.clear_state();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_limit(5'd31);
        directed_sequence();

        // limit at its floor, its ceiling and between
        wait_quiet();
        write_limit(5'd0);
        random_phase(RANDOM_PER_PHASE);
        wait_quiet();
        write_limit(5'd31);
        random_phase(RANDOM_PER_PHASE);
        wait_quiet();
        write_limit(5'd1);
        random_phase(RANDOM_PER_PHASE);
        wait_quiet();
        write_limit(5'($urandom_range(2, 30)));
        random_phase(RANDOM_PER_PHASE);

        wait_quiet();
        tracker.check_drained();

        $display("Covered %0d commands (%0d random), %0d frames, %0d words checked,",
                 tracker.commands, random_sent, tracker.frames, tracker.words_checked);
        $display("brightness limits 0, 1, 31 and one between; %0d mismatches.",
                 tracker.errors);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
